>>> design/hslrgb_pkg.sv
// Package for the HSL to RGB converter: constants, hue sector codes and the
// beat structures passed between pipeline sections. No dependencies.

package hslrgb_pkg;

	localparam int PIX_W = 16;
	localparam int W_W = 12;
	localparam int QUO_W = 20;
	localparam int RECIP_W = 20;
	localparam int RECIP_SHIFT = 23;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [15:0] SECTOR_UNITS = 16'd3840;
	localparam logic [15:0] TURN_UNITS = 16'd23040;
	localparam logic [15:0] SAT_MAX = 16'hFFFF;
	localparam logic [RECIP_W-1:0] RECIP_15 = 20'd559241;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW    = 3'd0,
		SEC_YELLOW_GREEN  = 3'd1,
		SEC_GREEN_CYAN    = 3'd2,
		SEC_CYAN_BLUE     = 3'd3,
		SEC_BLUE_MAGENTA  = 3'd4,
		SEC_MAGENTA_RED   = 3'd5
	} sector_t;

	typedef struct packed {
		logic            gray;
		sector_t         sector;
		logic [W_W-1:0]  w;
		logic [16:0]     t;
		logic [PIX_W-1:0] s;
		logic [PIX_W-1:0] l;
	} prep_beat_t;

	typedef struct packed {
		logic             gray;
		sector_t          sector;
		logic [PIX_W-1:0] c;
		logic [PIX_W-1:0] m;
		logic [QUO_W-1:0] q;
	} chroma_beat_t;

endpackage

>>> design/hslrgb_if.sv
// Stream interfaces for HSL input beats and RGB result beats.
// Depends on hslrgb_pkg for the field width.

interface hsl_if;
	logic                          valid;
	logic                          ready;
	logic [hslrgb_pkg::PIX_W-1:0]  hue;
	logic [hslrgb_pkg::PIX_W-1:0]  saturation;
	logic [hslrgb_pkg::PIX_W-1:0]  lightness;

	modport source (output valid, hue, saturation, lightness, input ready);
	modport sink (input valid, hue, saturation, lightness, output ready);
endinterface

interface rgb_if;
	logic                          valid;
	logic                          ready;
	logic [hslrgb_pkg::PIX_W-1:0]  red;
	logic [hslrgb_pkg::PIX_W-1:0]  green;
	logic [hslrgb_pkg::PIX_W-1:0]  blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

>>> design/hslrgb_hue_stage.sv
// First pipeline stage: hue sector decode, sector weight and lightness tent.
// Depends on hslrgb_pkg and hsl_if.

module hslrgb_hue_stage (
	input  logic                    clk,
	input  logic                    arst_n,
	hsl_if.sink                     hsl,
	output hslrgb_pkg::prep_beat_t  prep,
	output logic                    prep_valid,
	input  logic                    prep_ready
);

	hslrgb_pkg::sector_t sec;
	logic [15:0] base;
	logic [15:0] offs;
	logic [hslrgb_pkg::W_W-1:0] w;
	logic gray;
	logic [16:0] two_l;
	logic [16:0] dev;
	logic [16:0] t;
	logic valid_s1;
	hslrgb_pkg::prep_beat_t beat_s1;

	always_comb begin
		gray = 1'b0;
		if (hsl.hue < hslrgb_pkg::SECTOR_UNITS) begin
			sec = hslrgb_pkg::SEC_RED_YELLOW;
			base = 16'd0;
		end else if (hsl.hue < 16'(2 * hslrgb_pkg::SECTOR_UNITS)) begin
			sec = hslrgb_pkg::SEC_YELLOW_GREEN;
			base = 16'(1 * hslrgb_pkg::SECTOR_UNITS);
		end else if (hsl.hue < 16'(3 * hslrgb_pkg::SECTOR_UNITS)) begin
			sec = hslrgb_pkg::SEC_GREEN_CYAN;
			base = 16'(2 * hslrgb_pkg::SECTOR_UNITS);
		end else if (hsl.hue < 16'(4 * hslrgb_pkg::SECTOR_UNITS)) begin
			sec = hslrgb_pkg::SEC_CYAN_BLUE;
			base = 16'(3 * hslrgb_pkg::SECTOR_UNITS);
		end else if (hsl.hue < 16'(5 * hslrgb_pkg::SECTOR_UNITS)) begin
			sec = hslrgb_pkg::SEC_BLUE_MAGENTA;
			base = 16'(4 * hslrgb_pkg::SECTOR_UNITS);
		end else if (hsl.hue < hslrgb_pkg::TURN_UNITS) begin
			sec = hslrgb_pkg::SEC_MAGENTA_RED;
			base = 16'(5 * hslrgb_pkg::SECTOR_UNITS);
		end else begin
			sec = hslrgb_pkg::SEC_RED_YELLOW;
			base = hsl.hue;
			gray = 1'b1;
		end
		offs = hsl.hue - base;
		// Rising edge in even sectors, falling edge in odd ones.
		if (sec[0]) begin
			w = hslrgb_pkg::W_W'(hslrgb_pkg::SECTOR_UNITS - offs);
		end else begin
			w = offs[hslrgb_pkg::W_W-1:0];
		end
		two_l = {hsl.lightness, 1'b0};
		if (two_l[16]) begin
			dev = two_l - hslrgb_pkg::ONE_Q16;
		end else begin
			dev = hslrgb_pkg::ONE_Q16 - two_l;
		end
		t = hslrgb_pkg::ONE_Q16 - dev;
	end

	assign hsl.ready = !valid_s1 || prep_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hsl.ready) begin
			valid_s1 <= hsl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hsl.ready && hsl.valid) begin
			beat_s1.gray <= gray;
			beat_s1.sector <= sec;
			beat_s1.w <= w;
			beat_s1.t <= t;
			beat_s1.s <= hsl.saturation;
			beat_s1.l <= hsl.lightness;
		end
	end

	assign prep = beat_s1;
	assign prep_valid = valid_s1;

endmodule

>>> design/hslrgb_chroma.sv
// Second and third pipeline stages: chroma, offset and the scaled product
// of chroma and sector weight. Depends on hslrgb_pkg.

module hslrgb_chroma (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hslrgb_pkg::prep_beat_t    prep,
	input  logic                      prep_valid,
	output logic                      prep_ready,
	output hslrgb_pkg::chroma_beat_t  chroma,
	output logic                      chroma_valid,
	input  logic                      chroma_ready
);

	logic [32:0] ts_prod;
	logic valid_s2;
	logic gray_s2;
	hslrgb_pkg::sector_t sector_s2;
	logic [hslrgb_pkg::W_W-1:0] w_s2;
	logic [hslrgb_pkg::PIX_W-1:0] c_s2;
	logic [hslrgb_pkg::PIX_W-1:0] l_s2;
	logic ready_s2;

	logic [27:0] cw_prod;
	logic [hslrgb_pkg::PIX_W-1:0] half;
	logic [hslrgb_pkg::PIX_W-1:0] m;
	logic valid_s3;
	hslrgb_pkg::chroma_beat_t beat_s3;

	assign ts_prod = 33'(prep.t) * 33'(prep.s);
	assign prep_ready = !valid_s2 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (prep_ready) begin
			valid_s2 <= prep_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prep_ready && prep_valid) begin
			gray_s2 <= prep.gray;
			sector_s2 <= prep.sector;
			w_s2 <= prep.w;
			c_s2 <= ts_prod[31:16];
			l_s2 <= prep.l;
		end
	end

	always_comb begin
		cw_prod = 28'(c_s2) * 28'(w_s2);
		half = c_s2 >> 1;
		if (l_s2 >= half) begin
			m = l_s2 - half;
		end else begin
			m = '0;
		end
	end

	assign ready_s2 = !valid_s3 || chroma_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s2) begin
			valid_s3 <= valid_s2;
		end
	end

	// The division by 3840 starts here as a shift by 256; the factor 15 follows.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			beat_s3.gray <= gray_s2;
			beat_s3.sector <= sector_s2;
			beat_s3.c <= c_s2;
			beat_s3.m <= m;
			beat_s3.q <= cw_prod[27:8];
		end
	end

	assign chroma = beat_s3;
	assign chroma_valid = valid_s3;

endmodule

>>> design/hslrgb_mix.sv
// Fourth and fifth pipeline stages: division by fifteen through a reciprocal
// and the per-sector channel assignment. Depends on hslrgb_pkg and rgb_if.

module hslrgb_mix (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hslrgb_pkg::chroma_beat_t  chroma,
	input  logic                      chroma_valid,
	output logic                      chroma_ready,
	rgb_if.source                     rgb
);

	logic [39:0] recip_prod;
	logic valid_s4;
	hslrgb_pkg::chroma_beat_t beat_s4;
	logic [hslrgb_pkg::PIX_W-1:0] x_s4;
	logic ready_s4;

	logic [16:0] cm_sum;
	logic [16:0] xm_sum;
	logic [hslrgb_pkg::PIX_W-1:0] cm;
	logic [hslrgb_pkg::PIX_W-1:0] xm;
	logic [hslrgb_pkg::PIX_W-1:0] mm;
	logic [hslrgb_pkg::PIX_W-1:0] r;
	logic [hslrgb_pkg::PIX_W-1:0] g;
	logic [hslrgb_pkg::PIX_W-1:0] b;
	logic valid_s5;
	logic [hslrgb_pkg::PIX_W-1:0] red_s5;
	logic [hslrgb_pkg::PIX_W-1:0] green_s5;
	logic [hslrgb_pkg::PIX_W-1:0] blue_s5;

	assign recip_prod = 40'(chroma.q) * 40'(hslrgb_pkg::RECIP_15);
	assign chroma_ready = !valid_s4 || ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (chroma_ready) begin
			valid_s4 <= chroma_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chroma_ready && chroma_valid) begin
			beat_s4 <= chroma;
			x_s4 <= recip_prod[hslrgb_pkg::RECIP_SHIFT +: hslrgb_pkg::PIX_W];
		end
	end

	always_comb begin
		cm_sum = 17'(beat_s4.c) + 17'(beat_s4.m);
		xm_sum = 17'(x_s4) + 17'(beat_s4.m);
		cm = cm_sum[16] ? hslrgb_pkg::SAT_MAX : cm_sum[15:0];
		xm = xm_sum[16] ? hslrgb_pkg::SAT_MAX : xm_sum[15:0];
		mm = beat_s4.m;
		case (beat_s4.sector)
			hslrgb_pkg::SEC_RED_YELLOW: begin
				r = cm; g = xm; b = mm;
			end
			hslrgb_pkg::SEC_YELLOW_GREEN: begin
				r = xm; g = cm; b = mm;
			end
			hslrgb_pkg::SEC_GREEN_CYAN: begin
				r = mm; g = cm; b = xm;
			end
			hslrgb_pkg::SEC_CYAN_BLUE: begin
				r = mm; g = xm; b = cm;
			end
			hslrgb_pkg::SEC_BLUE_MAGENTA: begin
				r = xm; g = mm; b = cm;
			end
			default: begin
				r = cm; g = mm; b = xm;
			end
		endcase
		if (beat_s4.gray) begin
			r = mm; g = mm; b = mm;
		end
	end

	assign ready_s4 = !valid_s5 || rgb.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (ready_s4) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4 && valid_s4) begin
			red_s5 <= r;
			green_s5 <= g;
			blue_s5 <= b;
		end
	end

	assign rgb.valid = valid_s5;
	assign rgb.red = red_s5;
	assign rgb.green = green_s5;
	assign rgb.blue = blue_s5;

endmodule

>>> design/hsl_to_rgb_converter.sv
// Converts one HSL pixel to one RGB pixel per clock cycle while the output is not stalled.
// Top level of the converter; depends on hslrgb_pkg, hslrgb_if and the stage modules.

// The converter is a five-stage pipeline that takes one pixel in every clock
// cycle while the output is not stalled. Hue is in units of 1/64 degree;
// saturation, lightness and the three outputs are unsigned Q0.16 fractions,
// and any hue of 360 degrees or more gives a grey pixel. The stages hold the
// sector decode, the chroma multiply, the product of chroma and sector weight,
// the reciprocal multiply that divides by fifteen, and the channel
// assignment. Each stage holds its beat while the next one is full, so
// backpressure on the output stalls the pipeline without losing or repeating
// a pixel, and empty stages keep taking new beats.

module hsl_to_rgb_converter (
	input  logic  clk,
	input  logic  arst_n,
	hsl_if.sink   hsl,
	rgb_if.source rgb
);

	hslrgb_pkg::prep_beat_t prep;
	logic prep_valid;
	logic prep_ready;
	hslrgb_pkg::chroma_beat_t chroma;
	logic chroma_valid;
	logic chroma_ready;

	hslrgb_hue_stage u_hue_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsl        (hsl),
		.prep       (prep),
		.prep_valid (prep_valid),
		.prep_ready (prep_ready)
	);

	hslrgb_chroma u_chroma (
		.clk          (clk),
		.arst_n       (arst_n),
		.prep         (prep),
		.prep_valid   (prep_valid),
		.prep_ready   (prep_ready),
		.chroma       (chroma),
		.chroma_valid (chroma_valid),
		.chroma_ready (chroma_ready)
	);

	hslrgb_mix u_mix (
		.clk          (clk),
		.arst_n       (arst_n),
		.chroma       (chroma),
		.chroma_valid (chroma_valid),
		.chroma_ready (chroma_ready),
		.rgb          (rgb)
	);

endmodule

>>> dv/hsl_to_rgb_checker.sv
// Checker for the HSL to RGB converter: predicts each RGB beat from the accepted
// HSL beats and compares it with what the converter gives. Depends on hslrgb_pkg
// and the hsl_if and rgb_if interfaces.

module hsl_to_rgb_checker
	import hslrgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	hsl_if       hsl,
	rgb_if       rgb,
	output int   failures,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} rgb_pixel_t;

	rgb_pixel_t rgb_due[$];
	int         mismatches;

	function automatic logic [PIX_W-1:0] clamp16(input logic [16:0] v);
		return v[16] ? SAT_MAX : v[PIX_W-1:0];
	endfunction

	function automatic rgb_pixel_t hsl_pixel_to_rgb(input logic [PIX_W-1:0] hue,
			input logic [PIX_W-1:0] sat, input logic [PIX_W-1:0] light);
		logic [16:0]      two_l;
		logic [16:0]      dev;
		logic [16:0]      t;
		logic [32:0]      prod;
		logic [PIX_W-1:0] c;
		logic [PIX_W-1:0] half;
		logic [PIX_W-1:0] m;
		logic [PIX_W-1:0] cm;
		logic [PIX_W-1:0] xm;
		logic [PIX_W-1:0] pos;
		logic [PIX_W-1:0] f;
		logic [PIX_W-1:0] w;
		logic [31:0]      cw;
		logic [PIX_W-1:0] x;
		logic [PIX_W-1:0] sec_idx;
		rgb_pixel_t       px;
		two_l = {light, 1'b0};
		dev = (two_l >= ONE_Q16) ? two_l - ONE_Q16 : ONE_Q16 - two_l;
		t = ONE_Q16 - dev;
		prod = 33'(t) * 33'(sat);
		c = prod[31:16];
		half = c >> 1;
		m = (light >= half) ? light - half : '0;
		cm = clamp16({1'b0, c} + {1'b0, m});
		if (hue >= TURN_UNITS) begin
			px = '{red: m, green: m, blue: m};
		end else begin
			pos = PIX_W'(hue % (2 * SECTOR_UNITS));
			f = (pos >= SECTOR_UNITS) ? pos - SECTOR_UNITS : SECTOR_UNITS - pos;
			w = SECTOR_UNITS - f;
			cw = 32'(c) * 32'(w);
			x = PIX_W'(cw / 32'(SECTOR_UNITS));
			xm = clamp16({1'b0, x} + {1'b0, m});
			sec_idx = hue / SECTOR_UNITS;
			case (sector_t'(sec_idx[2:0]))
				SEC_RED_YELLOW: px = '{red: cm, green: xm, blue: m};
				SEC_YELLOW_GREEN: px = '{red: xm, green: cm, blue: m};
				SEC_GREEN_CYAN: px = '{red: m, green: cm, blue: xm};
				SEC_CYAN_BLUE: px = '{red: m, green: xm, blue: cm};
				SEC_BLUE_MAGENTA: px = '{red: xm, green: m, blue: cm};
				default: px = '{red: cm, green: m, blue: xm};
			endcase
		end
		return px;
	endfunction

	function automatic int compare_channel(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_pixel_t want;
		if (!arst_n) begin
			mismatches = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (hsl.valid && hsl.ready)
				rgb_due.push_back(hsl_pixel_to_rgb(hsl.hue, hsl.saturation, hsl.lightness));
			if (rgb.valid && rgb.ready) begin
				if (rgb_due.size() == 0) begin
					$display("%0t ns: unexpected beat, expected none, got %0d %0d %0d",
						$time, rgb.red, rgb.green, rgb.blue);
					mismatches++;
				end else begin
					want = rgb_due.pop_front();
					mismatches += compare_channel("red", want.red, rgb.red);
					mismatches += compare_channel("green", want.green, rgb.green);
					mismatches += compare_channel("blue", want.blue, rgb.blue);
				end
			end
			failures <= mismatches;
			pending <= rgb_due.size();
		end
	end

endmodule

>>> dv/tb_hsl_to_rgb_converter.sv
// Testbench top for the HSL to RGB converter: clock, reset, pixel stimulus with
// random gaps and output stalls, and the verdict. Depends on hslrgb_pkg, the
// stream interfaces, the converter and hsl_to_rgb_checker.

module tb_hsl_to_rgb_converter;
	import hslrgb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_PIXELS = 1330;
	localparam int STALL_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic steady;
	int   failures;
	int   pending;
	int   quiet_cycles;

	hsl_if hsl();
	rgb_if rgb();

	hsl_to_rgb_converter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsl    (hsl),
		.rgb    (rgb)
	);

	hsl_to_rgb_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.hsl      (hsl),
		.rgb      (rgb),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		rgb.ready <= steady || ($urandom_range(99) >= 26);
	end

	always @(posedge clk) begin
		if (!arst_n || (hsl.valid && hsl.ready) || (rgb.valid && rgb.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] h, input logic [PIX_W-1:0] s,
			input logic [PIX_W-1:0] l);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 26)
			gap = ($urandom_range(9) == 0) ? $urandom_range(6, 2) : 1;
		if (gap > 0) begin
			hsl.valid <= 1'b0;
			hsl.hue <= PIX_W'($urandom);
			hsl.saturation <= PIX_W'($urandom);
			hsl.lightness <= PIX_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		hsl.valid <= 1'b1;
		hsl.hue <= h;
		hsl.saturation <= s;
		hsl.lightness <= l;
		@(posedge clk);
		while (!hsl.ready) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_fraction();
		case ($urandom_range(19))
			0: return '0;
			1: return SAT_MAX;
			2: return 16'd32768;
			3: return 16'd32767;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] pick_hue();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return PIX_W'($urandom_range(65535, 23040));
		if (pick < 18)
			return PIX_W'(SECTOR_UNITS * $urandom_range(6) + $urandom_range(2) - 1);
		return PIX_W'($urandom_range(23039));
	endfunction

	initial begin
		arst_n = 1'b0;
		steady = 1'b0;
		hsl.valid = 1'b0;
		hsl.hue = '0;
		hsl.saturation = '0;
		hsl.lightness = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One pass over each sector boundary and the grey range, then the
		// extremes of saturation and lightness, including the clamped sum.
		send_pixel(16'd0, SAT_MAX, 16'd32768);
		send_pixel(16'd1920, SAT_MAX, 16'd32768);
		send_pixel(16'd3839, SAT_MAX, 16'd32768);
		send_pixel(16'd3840, SAT_MAX, 16'd32768);
		send_pixel(16'd7679, 16'd40000, 16'd20000);
		send_pixel(16'd7680, 16'd40000, 16'd20000);
		send_pixel(16'd11520, 16'd50000, 16'd45000);
		send_pixel(16'd13440, 16'd50000, 16'd45000);
		send_pixel(16'd15360, SAT_MAX, 16'd32767);
		send_pixel(16'd19200, SAT_MAX, 16'd32769);
		send_pixel(16'd23039, SAT_MAX, 16'd32768);
		send_pixel(16'd23040, SAT_MAX, 16'd32768);
		send_pixel(SAT_MAX, 16'd12345, 16'd54321);
		send_pixel(16'd5000, 16'd0, 16'd30000);
		send_pixel(16'd5000, SAT_MAX, 16'd0);
		send_pixel(16'd5000, SAT_MAX, SAT_MAX);
		send_pixel(16'd17000, 16'd0, 16'd0);
		send_pixel(16'd17000, SAT_MAX, 16'd1);
		send_pixel(16'd21000, SAT_MAX, 16'd65534);
		send_pixel(16'd9000, 16'd1, 16'd32768);
		send_pixel(16'd2500, 16'hAAAA, 16'h5555);
		send_pixel(16'd2500, 16'h5555, 16'hAAAA);

		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			steady <= (i >= 500) && (i < 750);
			send_pixel(pick_hue(), pick_fraction(), pick_fraction());
		end

		hsl.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
